FILE: hw/rtl/tsrr_pkg.sv
// shared types and codes for the task slot round robin scheduler
`default_nettype none
package tsrr_pkg;

  localparam int DEF_SLOTS  = 16;
  localparam int PROG_LEN_W = 24;
  localparam logic [PROG_LEN_W-1:0] MAX_LEN_RESET = 24'hFFFFFF;

  // operation codes
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_KILL    = 3'd1;
  localparam logic [2:0] OP_READY   = 3'd2;
  localparam logic [2:0] OP_RAN     = 3'd3;
  localparam logic [2:0] OP_SCHED   = 3'd4;
  localparam logic [2:0] OP_RESERVE = 3'd5;
  localparam logic [2:0] OP_RELEASE = 3'd6;

  // task types
  localparam logic [1:0] TYPE_USER   = 2'd0;
  localparam logic [1:0] TYPE_SYSTEM = 2'd1;

  // result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_BAD_TYPE = 3'd1;
  localparam logic [2:0] STAT_TOO_LONG = 3'd2;
  localparam logic [2:0] STAT_NO_SLOT  = 3'd3;
  localparam logic [2:0] STAT_BAD_SLOT = 3'd4;
  localparam logic [2:0] STAT_NOT_USER = 3'd5;

  typedef struct packed {
    logic [2:0]            op;
    logic [3:0]            slot;
    logic                  slot_in_range;
    logic [1:0]            kind;
    logic [PROG_LEN_W-1:0] program_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_out;
    logic       has_current;
    logic [3:0] current_slot;
    logic [4:0] live_tasks;
  } out_item_t;

  // status of the shared slot scanner
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } scan_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tsrr_scan.sv
// shared slot scanner: probes one slot per cycle with wrap-around
`default_nettype none
module tsrr_scan import tsrr_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [IDX_W-1:0] base,
  input  wire logic [CNT_W-1:0] steps,
  input  wire logic             match,
  output logic      [IDX_W-1:0] idx,
  output scan_stat_t            stat
);

  logic             busy;
  logic [CNT_W-1:0] remaining;
  logic             last;

  assign last       = (remaining == CNT_W'(1));
  assign stat.busy  = busy;
  assign stat.found = busy && match;
  assign stat.done  = busy && (match || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (stat.done) begin
      busy <= 1'b0;
    end
  end

  // pointer and step count
  always_ff @(posedge clk) begin
    if (start) begin
      idx       <= base;
      remaining <= steps;
    end else if (busy && !stat.done) begin
      idx       <= (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
      remaining <= remaining - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/task_slot_round_robin_scheduler_top.sv
// top level of the task slot round robin scheduler
//
// A table of SLOTS task slots with used, ready, ran, system and reserved
// flags, a current task and a live count. One operation goes in per input
// transfer and exactly one result comes out per operation. Kill, make
// ready, mark ran, reserve, release and the unused code finish at once:
// the result is shown the cycle after the input transfer and the next
// operation can be taken the cycle after the result transfer. Create and
// schedule walk the table with one shared scanner that probes one slot
// per cycle between the accept and the result; a create that is refused
// for type or length finishes at once, and so does a schedule whose
// current task has not yet run. The input side stalls from the input
// transfer until the result transfer. The program length limit is written
// through cfg_wr_en / cfg_wr_data; the user must write it only while the
// block is idle, as the block itself does not enforce this. It resets to
// the largest 24-bit value.
`default_nettype none
module task_slot_round_robin_scheduler_top import tsrr_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [PROG_LEN_W-1:0] cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LIVE_W = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  // slot table
  logic [SLOTS-1:0] in_use;
  logic [SLOTS-1:0] is_ready;
  logic [SLOTS-1:0] has_ran;
  logic [SLOTS-1:0] is_system;
  logic [SLOTS-1:0] reserved;

  logic              cur_valid;
  logic [IDX_W-1:0]  cur_idx;
  logic [LIVE_W-1:0] live;
  logic [PROG_LEN_W-1:0] max_len;

  // held for the operation in flight
  logic [2:0] op_reg;
  logic [1:0] type_reg;
  logic [2:0] status_reg;
  logic [IDX_W-1:0] given_reg;

  // decode of the incoming item
  logic             accept;
  logic             slot_ok;
  logic [IDX_W-1:0] sidx;
  logic             create_ok;
  logic             go_scan;
  logic             from_cur;

  // scanner hookup
  logic                      scan_start;
  logic [IDX_W-1:0]          scan_base;
  logic [$clog2(SLOTS+1)-1:0] scan_steps;
  logic                      scan_match;
  logic [IDX_W-1:0]          scan_idx;
  scan_stat_t                scan_stat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // slot field is 4 bits; it lies in the table only when below SLOTS
  assign slot_ok = in_data.slot_in_range && ({28'd0, in_data.slot} < 32'(SLOTS));
  assign sidx    = IDX_W'(in_data.slot);

  assign create_ok = (in_data.kind == TYPE_USER || in_data.kind == TYPE_SYSTEM)
                     && (in_data.program_length <= max_len);

  // schedule with a current task that has run starts just after it and
  // skips the current slot itself; otherwise the walk starts at slot zero
  always_comb begin
    from_cur = 1'b0;
    go_scan  = 1'b0;
    case (in_data.op)
      OP_CREATE: go_scan = create_ok;
      OP_SCHED: begin
        from_cur = cur_valid;
        go_scan  = !cur_valid || has_ran[cur_idx];
      end
      default: go_scan = 1'b0;
    endcase
    case (from_cur)
      1'b1: begin
        scan_base  = (cur_idx == IDX_W'(SLOTS - 1)) ? '0 : cur_idx + 1'b1;
        scan_steps = ($clog2(SLOTS+1))'(SLOTS - 1);
      end
      default: begin
        scan_base  = '0;
        scan_steps = ($clog2(SLOTS+1))'(SLOTS);
      end
    endcase
  end

  assign scan_start = accept && go_scan;

  // create looks for a free unreserved slot, schedule for a used ready one
  assign scan_match = (op_reg == OP_CREATE) ? (!in_use[scan_idx] && !reserved[scan_idx])
                                            : (in_use[scan_idx] && is_ready[scan_idx]);

  tsrr_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .base  (scan_base),
    .steps (scan_steps),
    .match (scan_match),
    .idx   (scan_idx),
    .stat  (scan_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_use    <= '0;
      is_ready  <= '0;
      has_ran   <= '0;
      is_system <= '0;
      reserved  <= '0;
      cur_valid <= 1'b0;
      cur_idx   <= '0;
      live      <= '0;
      max_len   <= MAX_LEN_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state      <= go_scan ? ST_SCAN : ST_DONE;
            op_reg     <= in_data.op;
            type_reg   <= in_data.kind;
            status_reg <= STAT_OK;
            given_reg  <= '0;
            case (in_data.op)
              OP_CREATE: begin
                if (!(in_data.kind == TYPE_USER || in_data.kind == TYPE_SYSTEM)) begin
                  status_reg <= STAT_BAD_TYPE;
                end else if (!create_ok) begin
                  status_reg <= STAT_TOO_LONG;
                end
              end
              OP_KILL: begin
                if (!slot_ok || !in_use[sidx]) begin
                  status_reg <= STAT_BAD_SLOT;
                end else if (is_system[sidx]) begin
                  status_reg <= STAT_NOT_USER;
                end else begin
                  if (cur_valid && cur_idx == sidx) begin
                    cur_valid <= 1'b0;
                    cur_idx   <= '0;
                  end
                  in_use[sidx] <= 1'b0;
                  if (live != '0) begin
                    live <= live - 1'b1;
                  end
                end
              end
              OP_READY: begin
                if (!slot_ok || !in_use[sidx]) begin
                  status_reg <= STAT_BAD_SLOT;
                end else begin
                  is_ready[sidx] <= 1'b1;
                end
              end
              OP_RAN: begin
                if (cur_valid) begin
                  has_ran[cur_idx] <= 1'b1;
                end
              end
              OP_RESERVE, OP_RELEASE: begin
                if (!slot_ok) begin
                  status_reg <= STAT_BAD_SLOT;
                end else begin
                  reserved[sidx] <= (in_data.op == OP_RESERVE);
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_stat.done) begin
            state <= ST_DONE;
            if (op_reg == OP_CREATE) begin
              if (scan_stat.found) begin
                in_use[scan_idx]    <= 1'b1;
                is_ready[scan_idx]  <= 1'b0;
                has_ran[scan_idx]   <= 1'b0;
                is_system[scan_idx] <= (type_reg == TYPE_SYSTEM);
                live                <= live + 1'b1;
                given_reg           <= scan_idx;
              end else begin
                status_reg <= STAT_NO_SLOT;
              end
            end else begin
              if (scan_stat.found) begin
                // round robin step clears the ran mark of the next task
                if (cur_valid) begin
                  has_ran[scan_idx] <= 1'b0;
                end
                cur_valid <= 1'b1;
                cur_idx   <= scan_idx;
              end else if (cur_valid) begin
                cur_valid <= 1'b0;
                cur_idx   <= '0;
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register: fields are held until the output transfer
  assign out_valid             = (state == ST_DONE);
  assign out_data.status       = status_reg;
  assign out_data.slot_out     = 4'(given_reg);
  assign out_data.has_current  = cur_valid;
  assign out_data.current_slot = cur_valid ? 4'(cur_idx) : 4'd0;
  assign out_data.live_tasks   = 5'(live);

  // live count tracks the used flags
  a_live_count: assert property (@(posedge clk) disable iff (rst)
    32'(live) == $countones(in_use))
    else $error("live count does not match used slots");

  // the current task always sits in a used slot
  a_cur_used: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> in_use[cur_idx])
    else $error("current task slot not in use");

  // scanner runs only while the sequencer waits for it
  a_scan_state: assert property (@(posedge clk) disable iff (rst)
    scan_stat.busy |-> state == ST_SCAN)
    else $error("scanner busy outside scan state");

  // a result transfer frees the input side
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !in_stall)
    else $error("input still stalled after result transfer");

  // a scan starts only from idle on an input transfer and then runs busy in the scan state
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    scan_start |=> scan_stat.busy && state == ST_SCAN)
    else $error("scan start not followed by scan");

endmodule
`default_nettype wire

FILE: sim/task_slot_round_robin_scheduler_top_test.sv
// self-checking testbench for the task slot round robin scheduler
`default_nettype none
module task_slot_round_robin_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tsrr_pkg::*;

  // the op code that has no operation behind it
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int PHASE_OPS = 120;
  localparam int HOLD_CYCLES = 250;

  // predicts the task table and holds the results still owed by the block
  class sched_scoreboard;
    bit [DEF_SLOTS-1:0] used, ready, ran, sys, resv;
    bit cur_ok;
    logic [3:0] cur;
    logic [4:0] live;
    logic [PROG_LEN_W-1:0] limit;
    out_item_t owed_q[$];
    int errors, n_ops, n_checked, n_sched, n_rotate;
    int stat_seen[8];

    function new();
      used = '0;
      ready = '0;
      ran = '0;
      sys = '0;
      resv = '0;
      cur_ok = 1'b0;
      cur = '0;
      live = '0;
      limit = MAX_LEN_RESET;
      errors = 0;
      n_ops = 0;
      n_checked = 0;
      n_sched = 0;
      n_rotate = 0;
      foreach (stat_seen[k]) stat_seen[k] = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    // apply one accepted operation and queue the result it must produce
    function void note_op(in_item_t it);
      out_item_t r;
      bit found;
      int c;
      r = '0;
      found = 1'b0;
      case (it.op)
        OP_CREATE: begin
          if (it.kind > TYPE_SYSTEM) begin
            r.status = STAT_BAD_TYPE;
          end else if (it.program_length > limit) begin
            r.status = STAT_TOO_LONG;
          end else begin
            r.status = STAT_NO_SLOT;
            // lowest slot that is free and not reserved
            for (int i = 0; i < DEF_SLOTS; i++) begin
              if (!found && !used[i] && !resv[i]) begin
                found = 1'b1;
                used[i] = 1'b1;
                ready[i] = 1'b0;
                ran[i] = 1'b0;
                sys[i] = (it.kind == TYPE_SYSTEM);
                live++;
                r.slot_out = i[3:0];
                r.status = STAT_OK;
              end
            end
          end
        end
        OP_KILL: begin
          if (!it.slot_in_range || !used[it.slot]) begin
            r.status = STAT_BAD_SLOT;
          end else if (sys[it.slot]) begin
            r.status = STAT_NOT_USER;
          end else begin
            if (cur_ok && cur == it.slot) begin
              cur_ok = 1'b0;
              cur = '0;
            end
            // ready and ran flags of the dead slot stay as they are
            used[it.slot] = 1'b0;
            if (live != 0) live--;
          end
        end
        OP_READY: begin
          if (!it.slot_in_range || !used[it.slot]) r.status = STAT_BAD_SLOT;
          else ready[it.slot] = 1'b1;
        end
        OP_RAN: begin
          if (cur_ok) ran[cur] = 1'b1;
        end
        OP_SCHED: begin
          n_sched++;
          if (!cur_ok) begin
            for (int i = 0; i < DEF_SLOTS; i++) begin
              if (!found && used[i] && ready[i]) begin
                found = 1'b1;
                cur_ok = 1'b1;
                cur = i[3:0];
              end
            end
          end else if (ran[cur]) begin
            // round robin after the current slot, never the current slot itself
            for (int i = 1; i < DEF_SLOTS; i++) begin
              c = (int'(cur) + i) % DEF_SLOTS;
              if (!found && used[c] && ready[c]) begin
                found = 1'b1;
                ran[c] = 1'b0;
                cur = c[3:0];
                n_rotate++;
              end
            end
            if (!found) begin
              cur_ok = 1'b0;
              cur = '0;
            end
          end
        end
        OP_RESERVE, OP_RELEASE: begin
          if (!it.slot_in_range) r.status = STAT_BAD_SLOT;
          else resv[it.slot] = (it.op == OP_RESERVE);
        end
        default: ;
      endcase
      r.has_current = cur_ok;
      r.current_slot = cur_ok ? cur : 4'd0;
      r.live_tasks = live;
      stat_seen[r.status]++;
      n_ops++;
      owed_q.push_back(r);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result with nothing owed: %p", got));
      end else begin
        want = owed_q.pop_front();
        n_checked++;
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.slot_out !== want.slot_out)
          report($sformatf("slot_out %0d, want %0d", got.slot_out, want.slot_out));
        if (got.has_current !== want.has_current)
          report($sformatf("has_current %0b, want %0b", got.has_current,
                           want.has_current));
        if (got.current_slot !== want.current_slot)
          report($sformatf("current_slot %0d, want %0d", got.current_slot,
                           want.current_slot));
        if (got.live_tasks !== want.live_tasks)
          report($sformatf("live_tasks %0d, want %0d", got.live_tasks,
                           want.live_tasks));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [PROG_LEN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  sched_scoreboard sb = new();
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int n_limits = 0;

  always #5 clk = ~clk;

  task_slot_round_robin_scheduler_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // mostly back to back, sometimes short pauses, rarely long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic in_item_t mk(logic [2:0] op, logic [3:0] slot, logic inr,
                                  logic [1:0] ttype, logic [PROG_LEN_W-1:0] len);
    in_item_t it;
    it.op = op;
    it.slot = slot;
    it.slot_in_range = inr;
    it.kind = ttype;
    it.program_length = len;
    return it;
  endfunction

  // random operation shaped to keep the table busy and the rotation moving
  function automatic in_item_t make_op();
    in_item_t it;
    int r;
    it.slot = 4'($urandom_range(0, DEF_SLOTS - 1));
    it.slot_in_range = ($urandom_range(0, 19) != 0);
    // lengths straddle the current limit, plus wide random and small ones
    case ($urandom_range(0, 3))
      0: it.program_length = PROG_LEN_W'($urandom);
      1: it.program_length = sb.limit;
      2: it.program_length = sb.limit + 1'b1;
      default: it.program_length = PROG_LEN_W'($urandom_range(0, 64));
    endcase
    // system tasks can never be killed, so keep them from clogging the table
    r = $urandom_range(0, 19);
    if (r < 2) it.kind = 2'($urandom_range(2, 3));
    else if (r < 5 && $countones(sb.sys & sb.used) < 5) it.kind = TYPE_SYSTEM;
    else it.kind = TYPE_USER;
    r = $urandom_range(0, 99);
    if (r < 20) it.op = OP_CREATE;
    else if (r < 32) it.op = OP_KILL;
    else if (r < 50) it.op = OP_READY;
    else if (r < 64) it.op = OP_RAN;
    else if (r < 82) it.op = OP_SCHED;
    else if (r < 89) it.op = OP_RESERVE;
    else if (r < 96) it.op = OP_RELEASE;
    else it.op = OP_UNUSED;
    // kill and ready mostly aim at live slots
    if (it.op == OP_KILL || it.op == OP_READY)
      repeat (4) if (!sb.used[it.slot]) it.slot = 4'($urandom_range(0, DEF_SLOTS - 1));
    return it;
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic push_op(input in_item_t it);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_op(it);
    @(negedge clk);
  endtask

  // drop valid and let every owed result drain, then wait out the scanner
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DEF_SLOTS + 2) @(negedge clk);
  endtask

  task automatic set_limit(input logic [PROG_LEN_W-1:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.limit = v;
    n_limits++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // every result transfer is checked against the oldest owed result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // output stall pattern, with one long hold-off that backs up the input side
  initial begin
    int r;
    int run_len;
    int held;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          out_stall <= 1'b0;
          run_len = $urandom_range(1, 40);
        end else begin
          out_stall <= 1'b1;
          if (r < 85) run_len = $urandom_range(1, 3);
          else if (r < 97) run_len = $urandom_range(4, 12);
          else run_len = $urandom_range(20, 60);
        end
        repeat (run_len - 1) @(negedge clk);
      end
    end
  end

  // main sequence
  initial begin
    logic [PROG_LEN_W-1:0] limits[5];
    limits[0] = 24'h000100;
    limits[1] = 24'h000000;
    limits[2] = PROG_LEN_W'($urandom);
    limits[3] = 24'hFFFFFF;
    limits[4] = 24'h7FFFFF;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk on the reset limit
    push_op(mk(OP_SCHED, 4'd0, 1'b1, TYPE_USER, '0));     // nothing ready, no current
    push_op(mk(OP_RAN, 4'd5, 1'b1, TYPE_USER, '0));       // mark ran with no current
    push_op(mk(OP_KILL, 4'd0, 1'b1, TYPE_USER, '0));      // kill of a free slot
    push_op(mk(OP_READY, 4'd15, 1'b1, TYPE_USER, '0));    // ready of a free slot
    push_op(mk(OP_CREATE, 4'd0, 1'b1, 2'd2, '0));         // invalid task types
    push_op(mk(OP_CREATE, 4'd0, 1'b1, 2'd3, '0));
    push_op(mk(OP_CREATE, 4'hF, 1'b0, TYPE_USER, 24'hFFFFFF)); // longest length
    push_op(mk(OP_CREATE, 4'd0, 1'b1, TYPE_SYSTEM, 24'h0));
    push_op(mk(OP_RESERVE, 4'd2, 1'b1, TYPE_USER, '0));   // create skips a reserved slot
    push_op(mk(OP_CREATE, 4'd0, 1'b1, TYPE_USER, 24'h1));
    push_op(mk(OP_RELEASE, 4'd2, 1'b1, TYPE_USER, '0));
    push_op(mk(OP_KILL, 4'd1, 1'b1, TYPE_USER, '0));      // system task is protected
    push_op(mk(OP_READY, 4'd0, 1'b1, TYPE_USER, '0));
    push_op(mk(OP_READY, 4'd3, 1'b1, TYPE_USER, '0));
    push_op(mk(OP_SCHED, 4'd0, 1'b1, TYPE_USER, '0));     // picks lowest ready
    push_op(mk(OP_SCHED, 4'd0, 1'b1, TYPE_USER, '0));     // not run yet, kept
    push_op(mk(OP_RAN, 4'd0, 1'b1, TYPE_USER, '0));
    push_op(mk(OP_SCHED, 4'd0, 1'b1, TYPE_USER, '0));     // rotates forward
    push_op(mk(OP_RAN, 4'd0, 1'b1, TYPE_USER, '0));
    push_op(mk(OP_SCHED, 4'd0, 1'b1, TYPE_USER, '0));     // wraps round
    push_op(mk(OP_KILL, 4'd0, 1'b1, TYPE_USER, '0));      // killing current clears it
    push_op(mk(OP_RESERVE, 4'd4, 1'b0, TYPE_USER, '0));   // id outside the table
    push_op(mk(OP_UNUSED, 4'd9, 1'b1, 2'd3, 24'hABCDEF));
    push_op(mk(OP_SCHED, 4'd0, 1'b1, TYPE_USER, '0));
    push_op(mk(OP_RAN, 4'd0, 1'b1, TYPE_USER, '0));
    push_op(mk(OP_SCHED, 4'd0, 1'b1, TYPE_USER, '0));     // no other ready, drops current
    push_op(mk(OP_READY, 4'd3, 1'b0, TYPE_USER, '0));

    // zero limit: only an empty program fits
    set_limit(24'h000000);
    push_op(mk(OP_CREATE, 4'd0, 1'b1, TYPE_USER, 24'h1));
    push_op(mk(OP_CREATE, 4'd0, 1'b1, TYPE_USER, 24'h0));

    // random phases, one limit setting each
    for (int p = 0; p < 5; p++) begin
      set_limit(limits[p]);
      if (p == 1) hold_go = 1'b1;
      repeat (PHASE_OPS) push_op(make_op());
    end

    wait_idle();
    repeat (DEF_SLOTS + 4) @(posedge clk);
    $display("covered %0d operations, %0d results checked, %0d limit settings",
             sb.n_ops, sb.n_checked, n_limits);
    $display("outcomes ok %0d, bad type %0d, too long %0d, no free slot %0d, ",
             sb.stat_seen[STAT_OK], sb.stat_seen[STAT_BAD_TYPE],
             sb.stat_seen[STAT_TOO_LONG], sb.stat_seen[STAT_NO_SLOT],
             "bad slot %0d, not user %0d, schedules %0d, rotations %0d",
             sb.stat_seen[STAT_BAD_SLOT], sb.stat_seen[STAT_NOT_USER],
             sb.n_sched, sb.n_rotate);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout: block stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
